// ===== src/lmd_pkg.sv =====
// ----------------------------------------------------------------------------
// LED peak meter package
// Shared field widths, item kinds and the command word passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package lmd_pkg;

  localparam int PEAK_W      = 13;
  localparam int MS_W        = 16;
  localparam int STEP_W      = 16;
  localparam int AMOUNT_W    = 32;
  localparam int CMD_STRIP_W = 4;
  localparam int ROW_SHIFT   = 12;
  localparam int ROW_HALF    = 2048;
  localparam int QUIET_LIMIT = 205;

  localparam logic KIND_PEAK = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic                   tick;
    logic [CMD_STRIP_W-1:0] strip;
    logic [AMOUNT_W-1:0]    amount;
  } lmd_cmd_t;

endpackage

// ===== src/lmd_queue.sv =====
// ----------------------------------------------------------------------------
// LED peak meter queue
// Small register FIFO with first-word fall-through read.
// ----------------------------------------------------------------------------
module lmd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/lmd_front.sv =====
// ----------------------------------------------------------------------------
// LED peak meter front end
// Accepts input words, drops out-of-range strips, scales peaks to rows and
// forms the tick decay amount, then hands a command to the queue.
// ----------------------------------------------------------------------------
module lmd_front #(
  parameter int STRIP_COUNT = 8,
  parameter int METER_LEDS  = 6,
  parameter int STRIP_W     = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic                       kind,
  input  logic [STRIP_W-1:0]         strip,
  input  logic [lmd_pkg::PEAK_W-1:0] peak,
  input  logic [lmd_pkg::MS_W-1:0]   elapsed_ms,
  input  logic [lmd_pkg::STEP_W-1:0] decay_step,
  output logic                       cmd_push,
  output lmd_pkg::lmd_cmd_t          cmd,
  input  logic                       cmd_full
);

  localparam int FULL_LEVEL = METER_LEDS * 4096;
  localparam int PROD_W     = lmd_pkg::PEAK_W + $clog2(METER_LEDS + 1);
  localparam int CMD_SW     = lmd_pkg::CMD_STRIP_W;
  localparam int AMT_W      = lmd_pkg::AMOUNT_W;

  logic                   hold_valid;
  logic                   accept;
  logic                   keep;
  logic [PROD_W-1:0]      rows_raw;
  logic [PROD_W-1:0]      rows;
  logic [AMT_W-1:0]       drop;
  lmd_pkg::lmd_cmd_t      cmd_next;

  assign full     = hold_valid && cmd_full;
  assign accept   = push && !full;
  assign cmd_push = hold_valid && !cmd_full;

  always_comb begin
    rows_raw = PROD_W'(peak) * PROD_W'(METER_LEDS);
    rows     = (rows_raw > PROD_W'(FULL_LEVEL)) ? PROD_W'(FULL_LEVEL) : rows_raw;
    drop     = AMT_W'(decay_step) * AMT_W'(elapsed_ms);
    keep     = (kind == lmd_pkg::KIND_TICK) || (32'(strip) < 32'(STRIP_COUNT));
    cmd_next.tick   = (kind == lmd_pkg::KIND_TICK);
    cmd_next.strip  = CMD_SW'(strip);
    cmd_next.amount = (kind == lmd_pkg::KIND_TICK) ? drop : AMT_W'(rows);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= keep;
    end else if (cmd_push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== src/lmd_back.sv =====
// ----------------------------------------------------------------------------
// LED peak meter back end
// Applies peak updates to strip levels and walks strips on a tick, one per
// cycle unless res_full stalls, holding a pending result to mark the last.
// ----------------------------------------------------------------------------
module lmd_back #(
  parameter int STRIP_COUNT = 8,
  parameter int METER_LEDS  = 6,
  parameter int STRIP_W     = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  decay_on,
  input  logic                  cmd_empty,
  input  lmd_pkg::lmd_cmd_t     cmd,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output logic [STRIP_W-1:0]    res_strip,
  output logic [METER_LEDS-1:0] res_leds,
  output logic                  res_last
);

  localparam int LEVEL_W = $clog2(METER_LEDS * 4096 + 1);
  localparam int CNT_W   = LEVEL_W + 1 - lmd_pkg::ROW_SHIFT;
  localparam int IDX_W   = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1;
  localparam int AMT_W   = lmd_pkg::AMOUNT_W;

  typedef enum logic [1:0] {IDLE, WALK, FLUSH} state_t;

  state_t                state;
  logic [IDX_W-1:0]      idx;
  logic [AMT_W-1:0]      drop;
  logic [LEVEL_W-1:0]    level   [STRIP_COUNT];
  logic [METER_LEDS-1:0] shown   [STRIP_COUNT];
  logic [STRIP_COUNT-1:0] sent;
  logic                  pend_valid;
  logic [STRIP_W-1:0]    pend_strip;
  logic [METER_LEDS-1:0] pend_leds;

  logic [IDX_W-1:0]      rd_idx;
  logic [LEVEL_W-1:0]    cur_level;
  logic [LEVEL_W-1:0]    rows;
  logic [LEVEL_W-1:0]    level_next;
  logic [METER_LEDS-1:0] bits;
  logic                  due;
  logic                  advance;

  function automatic logic [METER_LEDS-1:0] bar(input logic [LEVEL_W-1:0] lv);
    logic [LEVEL_W:0]      sum;
    logic [CNT_W-1:0]      n;
    logic [METER_LEDS-1:0] pat;
    sum = {1'b0, lv} + (LEVEL_W + 1)'(lmd_pkg::ROW_HALF);
    n   = sum[LEVEL_W:lmd_pkg::ROW_SHIFT];
    if (n == '0) begin
      n = CNT_W'(1);
    end
    if (n > CNT_W'(METER_LEDS)) begin
      n = CNT_W'(METER_LEDS);
    end
    for (int j = 0; j < METER_LEDS; j++) begin
      pat[j] = ((METER_LEDS - 1 - j) < int'(n));
    end
    if (lv < LEVEL_W'(lmd_pkg::QUIET_LIMIT)) begin
      pat = '0;
    end
    return pat;
  endfunction

  always_comb begin
    rd_idx     = (state == WALK) ? idx : cmd.strip[IDX_W-1:0];
    cur_level  = level[rd_idx];
    rows       = cmd.amount[LEVEL_W-1:0];
    level_next = (AMT_W'(cur_level) > drop) ? LEVEL_W'(AMT_W'(cur_level) - drop) : '0;
    bits       = bar(level_next);
    due        = !sent[idx] || (bits != shown[idx]);
    advance    = !(due && pend_valid && res_full);
  end

  assign cmd_pop   = (state == IDLE) && !cmd_empty;
  assign res_push  = pend_valid && !res_full &&
                     (((state == WALK) && due) || (state == FLUSH));
  assign res_strip = pend_strip;
  assign res_leds  = pend_leds;
  assign res_last  = (state == FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      idx        <= '0;
      drop       <= '0;
      sent       <= '0;
      pend_valid <= 1'b0;
      for (int i = 0; i < STRIP_COUNT; i++) begin
        level[i] <= '0;
        shown[i] <= '0;
      end
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd_pop) begin
            if (cmd.tick) begin
              drop  <= cmd.amount;
              idx   <= '0;
              state <= WALK;
            end else if (!decay_on || (rows > cur_level)) begin
              level[rd_idx] <= rows;
            end
          end
        end
        WALK: begin
          if (advance) begin
            level[idx] <= level_next;
            if (due) begin
              shown[idx] <= bits;
              sent[idx]  <= 1'b1;
              pend_valid <= 1'b1;
              pend_strip <= STRIP_W'(idx);
              pend_leds  <= bits;
            end
            if (idx == IDX_W'(STRIP_COUNT - 1)) begin
              state <= FLUSH;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        FLUSH: begin
          if (!pend_valid) begin
            state <= IDLE;
          end else if (!res_full) begin
            pend_valid <= 1'b0;
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/led_peak_meter_decay_top.sv =====
// ----------------------------------------------------------------------------
// LED peak meter with linear decay
// Multi-strip bar meter: peak updates raise or set strip levels, ticks decay
// them and report every strip whose bar pattern changed or was not yet sent.
// ----------------------------------------------------------------------------
// Input side is a queue: a word is taken when push is high and full is low.
// kind selects a peak update for one strip or a time tick. Results come out
// of a queue: the head word is valid while empty is low and leaves on pop. The
// user writes decay_step via decay_step_we / decay_step_wdata only while idle;
// the block itself does not enforce this.
// A word enters a one-entry front register, then a two-entry command queue.
// The back end applies a peak update as it pops it. A tick walks the strips
// one per cycle unless a result is due while the result queue is full; the
// back end takes no new command until the tick is done, so the strip walk is
// what sets the throughput of ticks.
// The last result of a tick is held in a pending register until the walk
// ends, then marked with last. When the receiver stalls the result queue
// fills, the walk holds, the command queue fills and full rises.
// Reset clears all levels, shown patterns and sent marks, and the queues.
// ----------------------------------------------------------------------------
module led_peak_meter_decay_top #(
  parameter int STRIP_COUNT = 8,
  parameter int METER_LEDS  = 6,
  localparam int STRIP_W    = (STRIP_COUNT > 8) ? $clog2(STRIP_COUNT) : 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       decay_step_we,
  input  logic [lmd_pkg::STEP_W-1:0] decay_step_wdata,
  input  logic                       push,
  output logic                       full,
  input  logic                       kind,
  input  logic [STRIP_W-1:0]         strip,
  input  logic [lmd_pkg::PEAK_W-1:0] peak,
  input  logic [lmd_pkg::MS_W-1:0]   elapsed_ms,
  input  logic                       pop,
  output logic                       empty,
  output logic [STRIP_W-1:0]         out_strip,
  output logic [METER_LEDS-1:0]      leds,
  output logic                       last
);

  localparam int CMD_W = $bits(lmd_pkg::lmd_cmd_t);
  localparam int RES_W = STRIP_W + METER_LEDS + 1;

  logic [lmd_pkg::STEP_W-1:0] decay_step;
  logic                       cmd_push;
  logic                       cmd_full;
  logic                       cmd_pop;
  logic                       cmd_empty;
  lmd_pkg::lmd_cmd_t          front_cmd;
  lmd_pkg::lmd_cmd_t          back_cmd;
  logic [CMD_W-1:0]           back_cmd_bits;
  logic                       res_push;
  logic                       res_full;
  logic [STRIP_W-1:0]         res_strip;
  logic [METER_LEDS-1:0]      res_leds;
  logic                       res_last;
  logic [RES_W-1:0]           res_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_step <= '0;
    end else if (decay_step_we) begin
      decay_step <= decay_step_wdata;
    end
  end

  lmd_front #(
    .STRIP_COUNT (STRIP_COUNT),
    .METER_LEDS  (METER_LEDS),
    .STRIP_W     (STRIP_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .strip      (strip),
    .peak       (peak),
    .elapsed_ms (elapsed_ms),
    .decay_step (decay_step),
    .cmd_push   (cmd_push),
    .cmd        (front_cmd),
    .cmd_full   (cmd_full)
  );

  lmd_queue #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (back_cmd_bits),
    .empty   (cmd_empty)
  );

  assign back_cmd = lmd_pkg::lmd_cmd_t'(back_cmd_bits);

  lmd_back #(
    .STRIP_COUNT (STRIP_COUNT),
    .METER_LEDS  (METER_LEDS),
    .STRIP_W     (STRIP_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .decay_on  (decay_step != '0),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_strip (res_strip),
    .res_leds  (res_leds),
    .res_last  (res_last)
  );

  lmd_queue #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data ({res_strip, res_leds, res_last}),
    .full    (res_full),
    .rd_en   (pop && !empty),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign out_strip = res_head[RES_W-1 -: STRIP_W];
  assign leds      = res_head[METER_LEDS:1];
  assign last      = res_head[0];

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

  a_pop_then_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> !res_push)
    else $error("result pushed right after a command was taken");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule
